/* sv/mtfg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtfg_pkg
// Shared widths, defaults and operation codes of the max-tree first-greater
// search block.
// ----------------------------------------------------------------------------
package mtfg_pkg;

	localparam int LEAVES_DEF     = 1024;
	localparam int VALUE_BITS_DEF = 20;

	localparam int OP_W   = 1;
	localparam int POS_W  = 11;
	localparam int THR_W  = 20;
	localparam int SIZE_W = 11;
	localparam int IDX_W  = 11;

	localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(1024);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

endpackage : mtfg_pkg
`default_nettype wire

/* sv/max_tree_first_greater_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// max_tree_first_greater_search
// Binary tree of maxima held in one synchronous memory. A write beat sets a
// leaf and walks its ancestors; a query beat returns the first position at
// or after the start, up to size_in_use, whose value exceeds the threshold.
//
// Input channel in_valid/in_ready carries operation, position and value.
// Output channel out_valid/out_ready carries found_index and found, one beat
// per query, none per write. Items are handled one at a time; in_ready is
// high while the engine is idle, also while a result waits on the output
// register.
// Write: the leaf is written on acceptance, then its ancestors up to the root,
// one ancestor per cycle through the read-modify-write loop.
// Query: each tree node checked costs a memory read plus a compare state.
// After reset a clearing pass writes zero to all 2*T nodes, T = LEAVES rounded
// up to a power of two; in_ready stays low meanwhile, cfg_we is taken as ever.
// A stalled receiver holds the result; a finished query then waits in its
// last state until the output register frees.
// ----------------------------------------------------------------------------
module max_tree_first_greater_search #(
	parameter int LEAVES     = mtfg_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = mtfg_pkg::VALUE_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [mtfg_pkg::SIZE_W-1:0]    cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire [mtfg_pkg::OP_W-1:0]      operation,
	input  wire [mtfg_pkg::POS_W-1:0]     position,
	input  wire [mtfg_pkg::THR_W-1:0]     value,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [mtfg_pkg::IDX_W-1:0]    found_index,
	output logic                          found
);
	import mtfg_pkg::*;

	localparam int LVL     = $clog2(LEAVES);
	localparam int TLEAVES = 1 << LVL;
	localparam int NODE_W  = LVL + 1;
	localparam int DEPTH   = 2 * TLEAVES;
	localparam int SZ_W    = $clog2(LEAVES + 1);
	localparam int IW      = (SZ_W > SIZE_W + 1) ? SZ_W : SIZE_W + 1;
	localparam int CMP_W   = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;

	localparam logic [IW-1:0]     LEAVES_C = IW'(LEAVES);
	localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_WUP    = 9'b000000100,
		ST_QLEAF  = 9'b000001000,
		ST_QUP    = 9'b000010000,
		ST_QUPCHK = 9'b000100000,
		ST_QDOWN  = 9'b001000000,
		ST_QDNCHK = 9'b010000000,
		ST_QDONE  = 9'b100000000
	} state_t;

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rd_data_q;

	state_t                state_q, state_d;
	logic [NODE_W-1:0]     node_q, node_d;
	logic [NODE_W-1:0]     clr_q;
	logic [VALUE_BITS-1:0] cur_q, cur_d;
	logic [THR_W-1:0]      thr_q, thr_d;
	logic                  hit_q, hit_d;
	logic [SIZE_W-1:0]     size_q;
	logic                  out_valid_q;
	logic [IDX_W-1:0]      found_index_q;
	logic                  found_q;

	logic                  wr_en;
	logic [NODE_W-1:0]     wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic [NODE_W-1:0]     rd_addr;
	logic                  load_out;

	logic                  in_beat;
	logic [IW-1:0]         size_ext, size_eff, start_s, start_m1, hit_pos, res_idx;
	logic [NODE_W-1:0]     start_leaf, node_par;
	logic                  pos_ok, rd_gt, res_found, out_free;
	logic [VALUE_BITS-1:0] wr_val, par_max;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_beat    = in_valid && in_ready;
	assign size_ext   = IW'(size_q);
	assign size_eff   = (size_ext > LEAVES_C) ? LEAVES_C : size_ext;
	assign start_s    = (position == '0) ? IW'(1) : IW'(position);
	assign start_m1   = start_s - IW'(1);
	assign start_leaf = {1'b1, start_m1[LVL-1:0]};
	assign pos_ok     = (position != '0) && (IW'(position) <= LEAVES_C);
	assign wr_val     = VALUE_BITS'(value);
	assign node_par   = node_q >> 1;
	assign rd_gt      = CMP_W'(rd_data_q) > CMP_W'(thr_q);
	assign par_max    = (cur_q > rd_data_q) ? cur_q : rd_data_q;
	assign hit_pos    = IW'(node_q[LVL-1:0]) + IW'(1);
	assign res_found  = hit_q && (hit_pos <= size_eff);
	assign res_idx    = res_found ? hit_pos : size_eff + IW'(1);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		node_d   = node_q;
		cur_d    = cur_q;
		thr_d    = thr_q;
		hit_d    = hit_q;
		wr_en    = 1'b0;
		wr_addr  = node_q;
		wr_data  = cur_q;
		rd_addr  = node_q;
		load_out = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_beat) begin
					if (operation == OP_WRITE) begin
						if (pos_ok) begin
							wr_en   = 1'b1;
							wr_addr = start_leaf;
							wr_data = wr_val;
							rd_addr = start_leaf ^ NODE_W'(1);
							node_d  = start_leaf;
							cur_d   = wr_val;
							state_d = ST_WUP;
						end
					end else begin
						thr_d   = value;
						hit_d   = 1'b0;
						node_d  = start_leaf;
						rd_addr = start_leaf;
						state_d = (start_s > size_eff) ? ST_QDONE : ST_QLEAF;
					end
				end
			end
			ST_WUP: begin
				wr_en   = 1'b1;
				wr_addr = node_par;
				wr_data = par_max;
				rd_addr = node_par ^ NODE_W'(1);
				node_d  = node_par;
				cur_d   = par_max;
				if (node_par == ROOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_QLEAF: begin
				if (rd_gt) begin
					hit_d   = 1'b1;
					state_d = ST_QDONE;
				end else begin
					state_d = ST_QUP;
				end
			end
			ST_QUP: begin
				if (node_q == ROOT) begin
					state_d = ST_QDONE;
				end else if (!node_q[0]) begin
					rd_addr = node_q | NODE_W'(1);
					node_d  = node_q | NODE_W'(1);
					state_d = ST_QUPCHK;
				end else begin
					node_d = node_par;
				end
			end
			ST_QUPCHK: begin
				if (rd_gt) begin
					state_d = ST_QDOWN;
				end else begin
					node_d  = node_par;
					state_d = ST_QUP;
				end
			end
			ST_QDOWN: begin
				if (node_q[LVL]) begin
					hit_d   = 1'b1;
					state_d = ST_QDONE;
				end else begin
					rd_addr = node_q << 1;
					node_d  = node_q << 1;
					state_d = ST_QDNCHK;
				end
			end
			ST_QDNCHK: begin
				if (!rd_gt) begin
					node_d = node_q | NODE_W'(1);
				end
				state_d = ST_QDOWN;
			end
			ST_QDONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// tree store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			size_q      <= SIZE_RST;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_q   <= hit_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		cur_q  <= cur_d;
		thr_q  <= thr_d;
		if (load_out) begin
			found_index_q <= res_idx[IDX_W-1:0];
			found_q       <= res_found;
		end
	end

	assign out_valid   = out_valid_q;
	assign found_index = found_index_q;
	assign found       = found_q;

	// outside the clearing pass a tree write never lands on the node read in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && state_q != ST_CLEAR |-> wr_addr != rd_addr)
		else $error("tree write and read collide");

	// a new result beat comes only out of a finished query
	a_out_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(state_q) == ST_QDONE)
		else $error("result beat without a query");

	// a write beat never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && operation == OP_WRITE |=> !$rose(out_valid))
		else $error("result beat after a write");

	// the clearing pass runs once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |=> state_q != ST_CLEAR)
		else $error("clearing pass restarted");

	// neither a search nor a write walk ever goes off the top of the tree
	a_node_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QUP || state_q == ST_QUPCHK || state_q == ST_QDOWN
		|| state_q == ST_QDNCHK || state_q == ST_WUP |-> node_q != '0)
		else $error("node index zero in tree walk");

endmodule : max_tree_first_greater_search
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max-tree first-greater search block. A local
// leaf table and size register predict each query answer at acceptance.
// Directed tests cover the table edges and size register corners. Random
// phases then mix writes, queries and noise; random sender gaps and receiver
// stalls are off in every third phase. Every result beat is checked in order
// against the predicted answers.
// ----------------------------------------------------------------------------
module tb_top;
	import mtfg_pkg::*;

	localparam int N_LEAVES      = LEAVES_DEF;
	localparam int VAL_W         = VALUE_BITS_DEF;
	localparam int CLK_PERIOD    = 4;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_ITEMS  = 2000;

	typedef struct {
		logic [IDX_W-1:0] index;
		logic             hit;
	} search_answer_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	logic              in_valid;
	op_t               operation;
	logic [POS_W-1:0]  position;
	logic [THR_W-1:0]  value;
	logic              out_ready;
	wire               in_ready;
	wire               out_valid;
	wire  [IDX_W-1:0]  found_index;
	wire               found;

	logic [VAL_W-1:0]  leaf_val [1:N_LEAVES];
	logic [SIZE_W-1:0] size_reg;
	search_answer_t    pending_answers [$];
	int                error_count = 0;
	bit                sender_gaps_on = 1'b1;
	bit                receiver_stalls_on = 1'b1;
	int                stall_left = 0;

	max_tree_first_greater_search #(
		.LEAVES     (N_LEAVES),
		.VALUE_BITS (VAL_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found_index (found_index),
		.found       (found)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(CLK_PERIOD * 3_000_000);
		$display("max_tree_first_greater_search regression: fail");
		$finish;
	end

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int unsigned eff_size();
		return (size_reg > N_LEAVES) ? N_LEAVES : size_reg;
	endfunction

	function automatic search_answer_t search_first_greater(logic [POS_W-1:0] start,
			logic [THR_W-1:0] thr);
		search_answer_t ans;
		int unsigned    lim;
		int unsigned    p;
		int unsigned    idx;
		lim = eff_size();
		idx = lim + 1;
		for (p = (start == 0) ? 1 : start; p <= lim; p++) begin
			if (leaf_val[p] > thr) begin
				idx = p;
				break;
			end
		end
		ans.index = idx[IDX_W-1:0];
		ans.hit = (idx <= lim);
		return ans;
	endfunction

	// receiver: ready with random stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (receiver_stalls_on && $urandom_range(0, 3) == 0)
				stall_left = gap_cycles();
		end
	end

	always @(posedge clk) begin
		search_answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				error_count++;
				$display("%0t: result beat with none expected, actual index %0d found %0b",
					$time, found_index, found);
			end else begin
				want = pending_answers.pop_front();
				if (found_index !== want.index) begin
					error_count++;
					$display("%0t: found_index mismatch, expected %0d, actual %0d",
						$time, want.index, found_index);
				end
				if (found !== want.hit) begin
					error_count++;
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, want.hit, found);
				end
			end
		end
	end

	task automatic apply_size(logic [SIZE_W-1:0] sz);
		cfg_we <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = sz;
	endtask

	task automatic send_beat(op_t op, logic [POS_W-1:0] pos, logic [THR_W-1:0] val);
		int n;
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		value <= val;
		do @(posedge clk); while (!in_ready);
		if (op == OP_WRITE) begin
			if (pos >= 1 && pos <= N_LEAVES)
				leaf_val[pos] = val;
		end else begin
			pending_answers.push_back(search_first_greater(pos, val));
		end
		if (sender_gaps_on && $urandom_range(0, 1) == 1) begin
			n = gap_cycles();
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off the sender until every answer is back and any write has finished
	task automatic settle_results();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] leaf_pattern();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2, 3, 4: return VAL_W'($urandom_range(0, 255));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic random_beat();
		int unsigned      lim;
		int unsigned      r;
		int unsigned      pos;
		int unsigned      probe;
		logic [THR_W-1:0] thr;
		lim = (eff_size() == 0) ? 1 : eff_size();
		r = $urandom_range(0, 99);
		if (r < 45) begin
			pos = ($urandom_range(0, 9) == 0) ? $urandom_range(1, N_LEAVES)
				: $urandom_range(1, lim);
			send_beat(OP_WRITE, POS_W'(pos), leaf_pattern());
		end else if (r < 92) begin
			case ($urandom_range(0, 9))
				0: pos = 0;
				1: pos = lim + 1;
				default: pos = $urandom_range(1, lim);
			endcase
			probe = $urandom_range(1, lim);
			case ($urandom_range(0, 3))
				0: thr = THR_W'($urandom);
				1: thr = THR_W'($urandom_range(0, 255));
				default: thr = THR_W'(leaf_val[probe] + $urandom_range(0, 2) - 1);
			endcase
			send_beat(OP_QUERY, POS_W'(pos), thr);
		end else begin
			send_beat(op_t'($urandom_range(0, 1)), POS_W'($urandom_range(0, 2047)),
				THR_W'($urandom));
		end
	endtask

	task automatic test_empty_table();
		send_beat(OP_QUERY, 1, 0);
		send_beat(OP_QUERY, 0, 0);
	endtask

	task automatic test_leaf_edges();
		send_beat(OP_WRITE, 1, '1);
		send_beat(OP_WRITE, N_LEAVES, '1);
		send_beat(OP_WRITE, 0, 5);
		send_beat(OP_WRITE, N_LEAVES + 1, 7);
		send_beat(OP_WRITE, 2047, 9);
		send_beat(OP_QUERY, 0, 0);
		send_beat(OP_QUERY, 2, 0);
		send_beat(OP_QUERY, N_LEAVES, 20'hFFFFE);
		send_beat(OP_QUERY, 1, '1);
		send_beat(OP_QUERY, N_LEAVES + 1, 0);
		send_beat(OP_QUERY, 2047, 0);
	endtask

	task automatic test_size_register();
		settle_results();
		apply_size(0);
		send_beat(OP_QUERY, 1, 0);
		settle_results();
		apply_size(2047);
		send_beat(OP_QUERY, 2, 0);
		settle_results();
		apply_size(1);
		send_beat(OP_QUERY, 1, 0);
		send_beat(OP_QUERY, 2, 0);
		settle_results();
		apply_size(512);
		send_beat(OP_WRITE, 600, 3);
		send_beat(OP_QUERY, 2, 0);
		settle_results();
		apply_size(1000);
		send_beat(OP_QUERY, 2, 2);
		send_beat(OP_QUERY, 600, 3);
		settle_results();
	endtask

	task automatic test_random_traffic();
		int phase_size [9];
		int per_phase;
		phase_size = '{1024, 16, 2047, 3, 300, 1025, 64, 1024, 0};
		phase_size[8] = $urandom_range(1, N_LEAVES);
		per_phase = RANDOM_ITEMS / 9;
		for (int i = 0; i < 9; i++) begin
			settle_results();
			apply_size(SIZE_W'(phase_size[i]));
			sender_gaps_on = (i % 3) != 1;
			receiver_stalls_on = (i % 3) != 1;
			for (int k = 0; k < per_phase; k++) begin
				if (k == per_phase / 2 && (i % 2) == 0)
					settle_results();
				random_beat();
			end
		end
		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		operation <= OP_WRITE;
		position <= '0;
		value <= '0;
		out_ready <= 1'b0;
		size_reg = SIZE_RST;
		for (int i = 1; i <= N_LEAVES; i++)
			leaf_val[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_leaf_edges();
		test_size_register();
		test_random_traffic();

		settle_results();
		if (error_count == 0)
			$display("max_tree_first_greater_search regression: pass");
		else
			$display("max_tree_first_greater_search regression: fail");
		$finish;
	end

endmodule
